>>> sv/qmm_pkg.sv
// Shared types and constants of the quad motor mixer.
// No dependencies; every other file of the block imports this package.
package qmm_pkg;

    localparam int MOTOR_W = 16;            // input fields and motor outputs
    localparam int MIX_W   = 18;            // signed mixed sums, [-65535, 131071]
    localparam int TOP_W   = 17;            // highest motor floored at 0
    localparam int NUM_MOTORS = 4;

    // configuration register indexes
    localparam logic [1:0] REG_MIXER_MODE    = 2'd0;
    localparam logic [1:0] REG_SPIN_THRUST   = 2'd1;
    localparam logic [1:0] REG_THRUST_CEIL   = 2'd2;
    localparam logic [1:0] REG_IDLE_THRUST   = 2'd3;

    // mixer modes
    localparam logic MODE_X    = 1'b0;
    localparam logic MODE_SPIN = 1'b1;

    localparam logic [MOTOR_W-1:0] CEIL_RESET = '1;

    typedef logic signed [MIX_W-1:0] mix_t;
    typedef mix_t [NUM_MOTORS-1:0] mix_vec_t;

    typedef struct packed {
        logic               mixer_mode;
        logic [MOTOR_W-1:0] spin_thrust;
        logic [MOTOR_W-1:0] thrust_ceiling;
        logic [MOTOR_W-1:0] idle_thrust;
    } cfg_t;

    typedef struct packed {
        logic [TOP_W-1:0] cut;
        logic             capped;
    } cap_t;

endpackage

>>> sv/qmm_mix.sv
// Stage 1 of the mixer: halves roll and pitch and forms the motor sums;
// in spin mode motors two and four take the spin thrust. Depends on qmm_pkg.
module qmm_mix
    import qmm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic        [MOTOR_W-1:0] thrust_cmd,
    input  logic signed [MOTOR_W-1:0] roll_cmd,
    input  logic signed [MOTOR_W-1:0] pitch_cmd,
    input  logic signed [MOTOR_W-1:0] yaw_cmd,
    input  cfg_t                      cfg,
    output logic                      out_valid,
    input  logic                      out_ready,
    output mix_vec_t                  mix
);

    logic signed [MOTOR_W:0]   roll_adj;
    logic signed [MOTOR_W:0]   pitch_adj;
    logic signed [MOTOR_W-1:0] half_r;
    logic signed [MOTOR_W-1:0] half_p;
    mix_t                      thr_x;
    mix_t                      hr_x;
    mix_t                      hp_x;
    mix_t                      yaw_x;
    mix_t                      spin_x;
    mix_vec_t                  mix_next;
    mix_vec_t                  mix_reg;
    logic                      valid_reg;

    // halve toward zero: add one to negative values before the shift
    assign roll_adj  = {roll_cmd[MOTOR_W-1], roll_cmd} + {{MOTOR_W{1'b0}}, roll_cmd[MOTOR_W-1]};
    assign pitch_adj = {pitch_cmd[MOTOR_W-1], pitch_cmd}
                       + {{MOTOR_W{1'b0}}, pitch_cmd[MOTOR_W-1]};
    assign half_r    = roll_adj[MOTOR_W:1];
    assign half_p    = pitch_adj[MOTOR_W:1];

    assign thr_x  = mix_t'({{(MIX_W-MOTOR_W){1'b0}}, thrust_cmd});
    assign spin_x = mix_t'({{(MIX_W-MOTOR_W){1'b0}}, cfg.spin_thrust});
    assign hr_x   = mix_t'(half_r);
    assign hp_x   = mix_t'(half_p);
    assign yaw_x  = mix_t'(yaw_cmd);

    always_comb
    begin
        if (cfg.mixer_mode == MODE_SPIN)
        begin
            mix_next[0] = thr_x - hr_x + hp_x;
            mix_next[1] = spin_x;
            mix_next[2] = thr_x + hr_x - hp_x;
            mix_next[3] = spin_x;
        end
        else
        begin
            mix_next[0] = thr_x - hr_x + hp_x + yaw_x;
            mix_next[1] = thr_x - hr_x - hp_x - yaw_x;
            mix_next[2] = thr_x + hr_x - hp_x + yaw_x;
            mix_next[3] = thr_x + hr_x + hp_x - yaw_x;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            mix_reg <= mix_next;
        end
    end

    assign out_valid = valid_reg;
    assign mix       = mix_reg;

endmodule

>>> sv/qmm_cap.sv
// Stages 2 and 3: highest motor floored at zero, then the excess over the ceiling.
// Depends on qmm_pkg.
module qmm_cap
    import qmm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  mix_vec_t in_mix,
    input  cfg_t     cfg,
    output logic     out_valid,
    input  logic     out_ready,
    output mix_vec_t out_mix,
    output cap_t     cap
);

    mix_t             max_a;
    mix_t             max_b;
    mix_t             max_all;
    logic [TOP_W-1:0] top_next;
    logic [TOP_W-1:0] top_reg;
    logic [TOP_W-1:0] ceil_x;
    mix_vec_t         mix_a_reg;
    mix_vec_t         mix_b_reg;
    cap_t             cap_next;
    cap_t             cap_reg;
    logic             a_valid_reg;
    logic             b_valid_reg;
    logic             a_ready;
    logic             b_ready;

    // stage A: pairwise maximum tree, negative result counts as zero
    assign max_a   = ($signed(in_mix[0]) > $signed(in_mix[1])) ? in_mix[0] : in_mix[1];
    assign max_b   = ($signed(in_mix[2]) > $signed(in_mix[3])) ? in_mix[2] : in_mix[3];
    assign max_all = ($signed(max_a) > $signed(max_b)) ? max_a : max_b;
    assign top_next = max_all[MIX_W-1] ? '0 : max_all[TOP_W-1:0];

    // stage B: excess over the ceiling
    assign ceil_x = {{(TOP_W-MOTOR_W){1'b0}}, cfg.thrust_ceiling};
    always_comb
    begin
        cap_next.capped = (top_reg > ceil_x);
        cap_next.cut    = cap_next.capped ? (top_reg - ceil_x) : '0;
    end

    assign b_ready  = !b_valid_reg || out_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_ready)
        begin
            mix_a_reg <= in_mix;
            top_reg   <= top_next;
        end
        if (a_valid_reg && b_ready)
        begin
            mix_b_reg <= mix_a_reg;
            cap_reg   <= cap_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_mix   = mix_b_reg;
    assign cap       = cap_reg;

endmodule

>>> sv/qmm_floor.sv
// Stage 4: subtracts the excess from every motor, applies the idle floor.
// Depends on qmm_pkg; holds the output register of the block.
module qmm_floor
    import qmm_pkg::*;
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  mix_vec_t                             in_mix,
    input  cap_t                                 cap,
    input  cfg_t                                 cfg,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [NUM_MOTORS-1:0][MOTOR_W-1:0]   motors,
    output logic                                 was_capped
);

    logic signed [MIX_W:0]              cut_x;
    logic signed [MIX_W:0]              idle_x;
    logic signed [MIX_W:0]              diff [NUM_MOTORS];
    logic [NUM_MOTORS-1:0][MOTOR_W-1:0] motors_next;
    logic [NUM_MOTORS-1:0][MOTOR_W-1:0] motors_reg;
    logic                               capped_reg;
    logic                               valid_reg;

    assign cut_x  = $signed({{(MIX_W+1-TOP_W){1'b0}}, cap.cut});
    assign idle_x = $signed({{(MIX_W+1-MOTOR_W){1'b0}}, cfg.idle_thrust});

    always_comb
    begin
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            diff[i] = (MIX_W+1)'($signed(in_mix[i])) - cut_x;
            motors_next[i] = (diff[i] < idle_x) ? cfg.idle_thrust : diff[i][MOTOR_W-1:0];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            motors_reg <= motors_next;
            capped_reg <= cap.capped;
        end
    end

    assign out_valid  = valid_reg;
    assign motors     = motors_reg;
    assign was_capped = capped_reg;

endmodule

>>> sv/quad_motor_mixer_with_cap.sv
// Quad X motor mixer with thrust ceiling and idle floor, top level.
// An accepted input word passes the stage registers of mix, cap A, cap B and floor to its output word.
// Throughput: one word per cycle while the output is not held; each of the four stages holds a word and
// advances when the stage after it is empty or moving.
// Reset (rst_n, async, active low) empties the pipeline and sets mode X,
// spin thrust 0, ceiling 65535, idle thrust 0.
module quad_motor_mixer_with_cap
    import qmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // motor_one, motor_two, motor_three, motor_four
    output logic        m_axis_tuser    // was_capped
);

    cfg_t cfg_reg;

    logic                               mix_valid;
    logic                               mix_ready;
    mix_vec_t                           mix;
    logic                               cap_valid;
    logic                               cap_ready;
    mix_vec_t                           cap_mix;
    cap_t                               cap;
    logic [NUM_MOTORS-1:0][MOTOR_W-1:0] motors;
    logic [MOTOR_W-1:0]                 out_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mixer_mode     <= MODE_X;
            cfg_reg.spin_thrust    <= '0;
            cfg_reg.thrust_ceiling <= CEIL_RESET;
            cfg_reg.idle_thrust    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIXER_MODE:  cfg_reg.mixer_mode     <= cfg_data[0];
                REG_SPIN_THRUST: cfg_reg.spin_thrust    <= cfg_data;
                REG_THRUST_CEIL: cfg_reg.thrust_ceiling <= cfg_data;
                REG_IDLE_THRUST: cfg_reg.idle_thrust    <= cfg_data;
                default:         cfg_reg                <= cfg_reg;
            endcase
        end
    end

    qmm_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .thrust_cmd (s_axis_tdata[15:0]),
        .roll_cmd   (s_axis_tdata[31:16]),
        .pitch_cmd  (s_axis_tdata[47:32]),
        .yaw_cmd    (s_axis_tdata[63:48]),
        .cfg        (cfg_reg),
        .out_valid  (mix_valid),
        .out_ready  (mix_ready),
        .mix        (mix)
    );

    qmm_cap u_cap (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_mix    (mix),
        .cfg       (cfg_reg),
        .out_valid (cap_valid),
        .out_ready (cap_ready),
        .out_mix   (cap_mix),
        .cap       (cap)
    );

    qmm_floor u_floor (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cap_valid),
        .in_ready   (cap_ready),
        .in_mix     (cap_mix),
        .cap        (cap),
        .cfg        (cfg_reg),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .motors     (motors),
        .was_capped (m_axis_tuser)
    );

    assign m_axis_tdata = motors;

    // every output lies in [idle, max(ceiling, idle)]
    assign out_hi = (cfg_reg.thrust_ceiling > cfg_reg.idle_thrust) ?
                    cfg_reg.thrust_ceiling : cfg_reg.idle_thrust;

    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (motors[0] >= cfg_reg.idle_thrust) && (motors[1] >= cfg_reg.idle_thrust)
                       && (motors[2] >= cfg_reg.idle_thrust) && (motors[3] >= cfg_reg.idle_thrust))
        else $error("motor below idle thrust");

    a_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (motors[0] <= out_hi) && (motors[1] <= out_hi)
                       && (motors[2] <= out_hi) && (motors[3] <= out_hi))
        else $error("motor above ceiling");

    // a capped word has its highest motor sitting on max(ceiling, idle)
    a_capped_top: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (motors[0] == out_hi) || (motors[1] == out_hi)
                                         || (motors[2] == out_hi) || (motors[3] == out_hi))
        else $error("capped word without a motor at the ceiling");

    // input backs up only when the output word is held
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled with the output free");

endmodule

>>> test/qmm_mix_checker.sv
// Checker for the quad motor mixer: tracks register writes, predicts the four
// motor values and the capped flag of each accepted setpoint, compares outputs.
// Depends on qmm_pkg for the register indexes, mode codes and cfg_t.
`timescale 1ns / 1ps

module qmm_mix_checker
    import qmm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [15:0]       cfg_data,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [63:0]       s_axis_tdata,   // thrust_cmd, roll_cmd, pitch_cmd, yaw_cmd
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [63:0]       m_axis_tdata,   // motor_one, motor_two, motor_three, motor_four
    input  logic              m_axis_tuser,   // was_capped
    output int unsigned       fail_count,
    output int unsigned       mixes_in_flight
);

    typedef struct packed {
        logic [NUM_MOTORS-1:0][MOTOR_W-1:0] motor;
        logic                               capped;
    } motor_set_t;

    const string motor_name [NUM_MOTORS] = '{"motor_one", "motor_two", "motor_three",
                                             "motor_four"};

    cfg_t        mix_cfg;
    motor_set_t  pending_mixes [$];
    int unsigned mismatches = 0;
    int unsigned in_flight = 0;

    assign fail_count      = mismatches;
    assign mixes_in_flight = in_flight;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic motor_set_t mix_motors(input logic [63:0] sp, input cfg_t c);
        int         thr;
        int         half_roll;
        int         half_pitch;
        int         yaw;
        int         top;
        int         cut;
        int         v;
        int         m [NUM_MOTORS];
        motor_set_t r;
        thr        = int'(sp[15:0]);
        // int division truncates toward zero, as the halving requires
        half_roll  = int'($signed(sp[31:16])) / 2;
        half_pitch = int'($signed(sp[47:32])) / 2;
        yaw        = int'($signed(sp[63:48]));
        if (c.mixer_mode == MODE_SPIN)
        begin
            m[0] = thr - half_roll + half_pitch;
            m[1] = int'(c.spin_thrust);
            m[2] = thr + half_roll - half_pitch;
            m[3] = int'(c.spin_thrust);
        end
        else
        begin
            m[0] = thr - half_roll + half_pitch + yaw;
            m[1] = thr - half_roll - half_pitch - yaw;
            m[2] = thr + half_roll - half_pitch + yaw;
            m[3] = thr + half_roll + half_pitch - yaw;
        end
        top = 0;
        cut = 0;
        foreach (m[i])
            if (m[i] > top)
                top = m[i];
        if (top > int'(c.thrust_ceiling))
            cut = top - int'(c.thrust_ceiling);
        foreach (m[i])
        begin
            v = m[i] - cut;
            if (v < int'(c.idle_thrust))
                v = int'(c.idle_thrust);
            r.motor[i] = v[MOTOR_W-1:0];
        end
        r.capped = (cut > 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        motor_set_t got;
        motor_set_t want;
        if (!rst_n)
        begin
            mix_cfg <= '{mixer_mode: MODE_X, spin_thrust: '0, thrust_ceiling: CEIL_RESET,
                         idle_thrust: '0};
            pending_mixes.delete();
            in_flight <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                pending_mixes.push_back(mix_motors(s_axis_tdata, mix_cfg));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.motor  = m_axis_tdata;
                got.capped = m_axis_tuser;
                if (pending_mixes.size() == 0)
                    report_mismatch($sformatf("output word %h/%b with no setpoint pending",
                                              m_axis_tdata, m_axis_tuser));
                else
                begin
                    want = pending_mixes.pop_front();
                    for (int i = 0; i < NUM_MOTORS; i++)
                        if (got.motor[i] !== want.motor[i])
                            report_mismatch($sformatf("%s expected %0d got %0d",
                                            motor_name[i], want.motor[i], got.motor[i]));
                    if (got.capped !== want.capped)
                        report_mismatch($sformatf("was_capped expected %b got %b",
                                                  want.capped, got.capped));
                end
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_MIXER_MODE:  mix_cfg.mixer_mode     <= cfg_data[0];
                    REG_SPIN_THRUST: mix_cfg.spin_thrust    <= cfg_data;
                    REG_THRUST_CEIL: mix_cfg.thrust_ceiling <= cfg_data;
                    REG_IDLE_THRUST: mix_cfg.idle_thrust    <= cfg_data;
                    default: ;
                endcase
            end
            in_flight <= pending_mixes.size();
        end
    end

endmodule

>>> test/tb_top.sv
// Top of the quad motor mixer testbench: clock, reset, setpoint stimulus in
// bursts, output back-pressure, register settings and the verdict.
// Depends on qmm_pkg, quad_motor_mixer_with_cap and qmm_mix_checker.
`timescale 1ns / 1ps

module tb_top
    import qmm_pkg::*;
();

    localparam int RUN_LIMIT = 200000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    int unsigned mix_fail_count;
    int unsigned mixes_in_flight;
    int unsigned burst_left = 0;

    quad_motor_mixer_with_cap dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    qmm_mix_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (mix_fail_count),
        .mixes_in_flight (mixes_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // output back-pressure: m_axis_tready replays a 16-bit ready pattern, re-chosen at random
    initial
    begin : out_stall
        logic [15:0] ready_pattern;
        int          phase;
        ready_pattern = '1;
        phase = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (phase % 48 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = '1;
                    1: ready_pattern = 16'($urandom) | 16'h0101;
                    2: ready_pattern = 16'h00FF;
                    default: ready_pattern = 16'($urandom);
                endcase
            end
            m_axis_tready <= ready_pattern[phase % 16];
            phase++;
        end
    end

    function automatic logic [63:0] pack_setpoint(input logic [15:0] thr, input logic [15:0] roll,
                                                  input logic [15:0] pitch,
                                                  input logic [15:0] yaw);
        return {yaw, pitch, roll, thr};
    endfunction

    // mostly full-range values, with extremes and small magnitudes mixed in
    function automatic logic [15:0] rand_field();
        logic [15:0] corner [5] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h0001};
        case ($urandom_range(0, 9))
            0: return corner[$urandom_range(0, 4)];
            1: return 16'($urandom_range(0, 15));
            2: return -16'($urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_setpoint(input logic [63:0] sp);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sp;
        do
            @(posedge clk);
        while (!s_axis_tready);
        burst_left--;
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count)
            send_setpoint(pack_setpoint(rand_field(), rand_field(), rand_field(), rand_field()));
    endtask

    // hold the sender until every output word is back, then let the pipe drain
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (mixes_in_flight != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [15:0] mode_data, input logic [15:0] spin,
                                input logic [15:0] ceil, input logic [15:0] idle);
        write_reg(REG_MIXER_MODE, mode_data);
        write_reg(REG_SPIN_THRUST, spin);
        write_reg(REG_THRUST_CEIL, ceil);
        write_reg(REG_IDLE_THRUST, idle);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (RUN_LIMIT) @(posedge clk);
        $display("quad_motor_mixer_with_cap verification failed");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= REG_MIXER_MODE;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, X mix: zero input, corners, halving toward zero, capping
        send_setpoint(pack_setpoint(16'd0, 16'd0, 16'd0, 16'd0));
        send_setpoint(pack_setpoint(16'hFFFF, 16'd0, 16'd0, 16'd0));
        send_setpoint(pack_setpoint(16'hFFFF, 16'h8000, 16'h8000, 16'h8000));
        send_setpoint(pack_setpoint(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_setpoint(pack_setpoint(16'd0, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_setpoint(pack_setpoint(16'd0, -16'd3, 16'd3, 16'd0));
        send_setpoint(pack_setpoint(16'd0, -16'd1, 16'd1, -16'd1));
        send_setpoint(pack_setpoint(16'd100, 16'd1, -16'd1, 16'd1));
        send_setpoint(pack_setpoint(16'd0, 16'd0, 16'd0, 16'h8000));
        send_setpoint(pack_setpoint(16'd40000, 16'h8000, 16'h7FFF, 16'h7FFF));
        send_setpoint(pack_setpoint(16'd0, 16'h7FFF, 16'h7FFF, 16'd0));
        send_setpoint(pack_setpoint(16'd32768, 16'd0, 16'd0, 16'h8000));
        send_random(30);
        drain_outputs();

        // spin mix; upper mode bits set and dropped; yaw must have no effect
        apply_config(16'hFFFF, 16'd30000, 16'd50000, 16'd500);
        send_setpoint(pack_setpoint(16'd0, 16'h7FFF, 16'h8000, 16'h7FFF));
        send_setpoint(pack_setpoint(16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000));
        send_setpoint(pack_setpoint(16'd0, -16'd3, -16'd1, 16'd5));
        send_setpoint(pack_setpoint(16'd1000, 16'd0, 16'd0, 16'h7FFF));
        send_random(60);
        drain_outputs();

        // ceiling 0 with maximum idle and spin thrust
        apply_config({15'h0001, MODE_SPIN}, 16'hFFFF, 16'd0, 16'hFFFF);
        send_random(40);
        drain_outputs();

        // X mix, everything at the low extreme
        apply_config({15'h7FFF, MODE_X}, 16'd0, 16'd0, 16'd0);
        send_random(50);
        drain_outputs();

        // mid-range settings, with a full drain partway through
        apply_config({15'h0000, MODE_X}, 16'h1234, 16'd30000, 16'd2000);
        send_random(35);
        drain_outputs();
        send_random(35);
        drain_outputs();

        repeat (4)
        begin
            apply_config(16'($urandom), 16'($urandom), 16'($urandom_range(20000, 65535)),
                         16'($urandom_range(0, 3000)));
            send_random(46);
            drain_outputs();
        end

        repeat (10) @(posedge clk);
        if (mix_fail_count == 0)
            $display("quad_motor_mixer_with_cap verification clean");
        else
            $display("quad_motor_mixer_with_cap verification failed");
        $finish;
    end

endmodule
